@@ sv/lphsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lphsd_pkg
// Shared widths, constants and the 16*log2 helper for the log-scale
// peak-hold spectrum display slot updater.
// ----------------------------------------------------------------------------
package lphsd_pkg;

    // field widths
    localparam int POWER_W = 16;
    localparam int SLOT_W  = 7;
    localparam int LEVEL_W = 6;
    localparam int GAIN_W  = 3;
    localparam int LOG_W   = 8;
    localparam int FRAC_W  = 4;
    localparam int POS_W   = 4;

    // tdata widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // level store geometry: one entry per display slot
    localparam int DISPLAY_SLOTS = 2 ** SLOT_W;

    localparam logic [SLOT_W-1:0]  BLANK_SLOT = SLOT_W'(DISPLAY_SLOTS / 2 - 1);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;
    localparam logic [LEVEL_W-1:0] DECAY_STEP = LEVEL_W'(2);
    localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(2);

    // fractional part of 16*log2 for the six bits below the leading one
    localparam logic [FRAC_W-1:0] FRAC_TBL [64] = '{
        4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd1,  4'd2,  4'd2,
        4'd2,  4'd3,  4'd3,  4'd3,  4'd3,  4'd4,  4'd4,  4'd4,
        4'd5,  4'd5,  4'd5,  4'd6,  4'd6,  4'd6,  4'd6,  4'd7,
        4'd7,  4'd7,  4'd7,  4'd8,  4'd8,  4'd8,  4'd8,  4'd9,
        4'd9,  4'd9,  4'd9,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12,
        4'd12, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd14, 4'd14,
        4'd14, 4'd14, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
    };

    // 16*log2 of the power value, zero maps to zero
    function automatic logic [LOG_W-1:0] log16(input logic [POWER_W-1:0] n);
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   shamt;
        logic [POWER_W-1:0] norm;
        pos = '0;
        // leading one position, highest set bit wins
        for (int i = 0; i < POWER_W; i++)
        begin
            if (n[i])
                pos = POS_W'(i);
        end
        // move the leading one up to the top bit
        shamt = POS_W'(POWER_W - 1) - pos;
        norm  = n << shamt;
        if (n == '0)
            return '0;
        return {pos, FRAC_TBL[norm[POWER_W-2 -: 6]]};
    endfunction

endpackage

@@ sv/lphsd_ram.sv @@
// ----------------------------------------------------------------------------
// lphsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lphsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

@@ sv/log_peak_hold_spectrum_display.sv @@
// ----------------------------------------------------------------------------
// log_peak_hold_spectrum_display
// Log-scale fast-attack / slow-release peak hold for spectrum display slots.
// ----------------------------------------------------------------------------
// path: an input transfer is registered in stage 1, its result in the result register on m_axis
// throughput: one item per cycle unless m_axis stalls; the level store read
//   is issued at the input transfer and the write-back of the previous item is forwarded
// reset: valid bits of all 128 slots clear at once, so every level reads as
//   zero; no clearing pass, gain_shift returns to 2
module log_peak_hold_spectrum_display (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: gain_shift
    input  logic                               cfg_we,
    input  logic [lphsd_pkg::GAIN_W-1:0]       cfg_wdata,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lphsd_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // power[15:0], slot[22:16]
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lphsd_pkg::M_TDATA_W-1:0]    m_axis_tdata   // slot_out[6:0], level[12:7]
);

    localparam int SLOT_W  = lphsd_pkg::SLOT_W;
    localparam int LEVEL_W = lphsd_pkg::LEVEL_W;
    localparam int POWER_W = lphsd_pkg::POWER_W;
    localparam int LOG_W   = lphsd_pkg::LOG_W;

    // input fields
    logic [POWER_W-1:0] in_power;
    logic [SLOT_W-1:0]  in_slot;

    // handshake
    logic in_fire;
    logic s1_adv;
    logic s1_fire;

    // configuration register
    logic [lphsd_pkg::GAIN_W-1:0] gain_reg;

    // stage 1: input register
    logic                 s1_valid_reg, s1_valid_next;
    logic [POWER_W-1:0]   s1_power_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;
    logic                 s1_vsnap_reg;
    logic                 byp_reg;
    logic [LEVEL_W-1:0]   byp_level_reg;

    // level store valid bits
    logic [lphsd_pkg::DISPLAY_SLOTS-1:0] valid_reg, valid_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [LEVEL_W-1:0]   out_level_reg;

    // stage 1 datapath
    logic [LEVEL_W-1:0]   ram_rdata;
    logic [LEVEL_W-1:0]   stored_level;
    logic [LOG_W-1:0]     log_val;
    logic [LOG_W-1:0]     shifted;
    logic [LEVEL_W-1:0]   val_sat;
    logic [LEVEL_W-1:0]   new_level;

    assign in_power = s_axis_tdata[POWER_W-1:0];
    assign in_slot  = s_axis_tdata[POWER_W +: SLOT_W];

    // handshake: stage 1 moves on when the result register is free or drains
    assign s1_adv        = !out_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && s1_adv;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // gain register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= lphsd_pkg::GAIN_RESET;
        else if (cfg_we)
            gain_reg <= cfg_wdata;
    end

    // level store, read on the input transfer, written from stage 1
    lphsd_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (lphsd_pkg::DISPLAY_SLOTS)
    ) u_level_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_slot_reg),
        .wdata (new_level),
        .re    (in_fire),
        .raddr (in_slot),
        .rdata (ram_rdata)
    );

    // stored level: forwarded write-back, else store, else reset value
    always_comb
    begin
        if (byp_reg)
            stored_level = byp_level_reg;
        else if (s1_vsnap_reg)
            stored_level = ram_rdata;
        else
            stored_level = '0;
    end

    // log value, gain shift and saturation
    always_comb
    begin
        log_val = lphsd_pkg::log16(s1_power_reg);
        shifted = log_val >> gain_reg;
        if (shifted > LOG_W'(lphsd_pkg::LEVEL_MAX))
            val_sat = lphsd_pkg::LEVEL_MAX;
        else
            val_sat = shifted[LEVEL_W-1:0];
    end

    // fast attack, slow release, blanked slot forced to zero
    always_comb
    begin
        if (s1_slot_reg == lphsd_pkg::BLANK_SLOT)
            new_level = '0;
        else if (val_sat >= stored_level)
            new_level = val_sat;
        else if (stored_level > lphsd_pkg::DECAY_STEP)
            new_level = stored_level - lphsd_pkg::DECAY_STEP;
        else
            new_level = '0;
    end

    // valid bits set on write-back
    always_comb
    begin
        valid_next = valid_reg;
        if (s1_fire)
            valid_next[s1_slot_reg] = 1'b1;
    end

    // control next values
    always_comb
    begin
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_adv)
            out_valid_next = s1_valid_reg;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (in_fire)
                byp_reg <= s1_fire && (s1_slot_reg == in_slot);
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_power_reg  <= in_power;
            s1_slot_reg   <= in_slot;
            s1_vsnap_reg  <= valid_reg[in_slot];
            byp_level_reg <= new_level;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_slot_reg  <= s1_slot_reg;
            out_level_reg <= new_level;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(lphsd_pkg::M_TDATA_W - SLOT_W - LEVEL_W)'(0),
                            out_level_reg, out_slot_reg};

`ifndef SYNTHESIS
    // blanked slot is always shown as zero
    a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_slot_reg == lphsd_pkg::BLANK_SLOT)
        |-> (out_level_reg == '0))
        else $error("blanked slot shows a nonzero level");

    // no new item taken while stage 1 is stuck behind a full result register
    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while stage 1 stalls");

    // a written slot is marked valid afterwards
    a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> valid_reg[$past(s1_slot_reg)])
        else $error("valid bit not set after write-back");

    // a write-back to the slot of the incoming transfer is always forwarded
    a_bypass_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && s1_fire && (s1_slot_reg == in_slot) |=> byp_reg)
        else $error("missed forwarding of same-slot write-back");
`endif

endmodule
